// File: rtl/smis_pkg.sv
// ----------------------------------------------------------------------------
// smis_pkg: shared types and constants of the stack machine step block
// Opcodes, status codes, command codes and the controller/datapath interface.
// ----------------------------------------------------------------------------
package smis_pkg;

    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_EXEC  = 2'd2;

    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_IO     = 3'd1;
    localparam logic [2:0] ST_KEY    = 3'd2;
    localparam logic [2:0] ST_DOVER  = 3'd3;
    localparam logic [2:0] ST_DUNDER = 3'd4;
    localparam logic [2:0] ST_COVER  = 3'd5;
    localparam logic [2:0] ST_CUNDER = 3'd6;
    localparam logic [2:0] ST_DIVZ   = 3'd7;

    localparam logic [7:0] OP_PUSH  = 8'h01;
    localparam logic [7:0] OP_POP   = 8'h02;
    localparam logic [7:0] OP_CLEAR = 8'h03;
    localparam logic [7:0] OP_ADD   = 8'h04;
    localparam logic [7:0] OP_SUB   = 8'h05;
    localparam logic [7:0] OP_MUL   = 8'h06;
    localparam logic [7:0] OP_DIV   = 8'h07;
    localparam logic [7:0] OP_MOD   = 8'h08;
    localparam logic [7:0] OP_NAND  = 8'h09;
    localparam logic [7:0] OP_EQ    = 8'h0a;
    localparam logic [7:0] OP_LESS  = 8'h0b;
    localparam logic [7:0] OP_JNZ   = 8'h0c;
    localparam logic [7:0] OP_JMP   = 8'h0d;
    localparam logic [7:0] OP_CALL  = 8'h0e;
    localparam logic [7:0] OP_RET   = 8'h0f;
    localparam logic [7:0] OP_LOAD  = 8'h10;
    localparam logic [7:0] OP_STORE = 8'h11;
    localparam logic [7:0] OP_KEY   = 8'h12;
    localparam logic [7:0] OP_IO    = 8'h18;

    localparam logic [7:0] IO_CLR_A = 8'd3;
    localparam logic [7:0] IO_CLR_B = 8'd4;
    localparam logic [7:0] IO_NONE  = 8'hff;
    localparam logic [3:0] SCREEN_PAGE = 4'hf;

    localparam logic REG_BREAK = 1'b0;
    localparam logic REG_KEYS  = 1'b1;

    typedef enum logic [3:0] {
        PH_NONE, PH_ACCEPT, PH_HOSTRD, PH_FETCH, PH_OP, PH_B, PH_C,
        PH_EXEC, PH_DIV, PH_DIVWB, PH_CLR, PH_KADDR, PH_KEY
    } phase_t;

    typedef enum logic [1:0] {NX_DONE, NX_KEY, NX_DIV, NX_CLR} next_t;

    typedef enum logic [3:0] {
        S_IDLE, S_RD, S_FETCH, S_OP, S_B, S_C, S_EXEC, S_DIV, S_DIVWB,
        S_CLR, S_KADDR, S_KEY, S_DONE
    } state_t;

    typedef struct packed {
        phase_t phase;
        logic   out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] in_cmd;
        next_t      nxt;
        logic       div_last;
        logic       clr_last;
        logic       out_busy;
    } dp_stat_t;

endpackage

// File: rtl/stack_machine_instruction_step.sv
// ----------------------------------------------------------------------------
// stack_machine_instruction_step: 8-bit stack machine, one command per item
// Host memory write and read, or execution of one instruction at pc.
// ----------------------------------------------------------------------------
//  channel   handshake             payload
//  in        in_valid / in_ready   cmd, addr, data
//  out       out_valid / out_ready status, read_data, io_code, pc_out
//  cfg       cfg_we                cfg_index, cfg_data
//
// A host write goes straight to the result, a host read adds a memory read, and
// an instruction reads opcode and operands in turn, set by the single read port
// of the memory and of the data stack. Divide and modulo add the bit-serial
// divider; I/O codes 3 and 4 add a screen clear, one write per cleared byte.
// Reset is asynchronous; memory and stack contents are not cleared.
// A new item is taken while the previous result waits in the output register;
// a finished item waits in the sequencer while that register is still full.
// ----------------------------------------------------------------------------
module stack_machine_instruction_step #(
    parameter int DATA_STACK_DEPTH = 256,
    parameter int CALL_STACK_DEPTH = 256,
    parameter int ROM_TOP          = 40960
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  cmd,
    input  logic [15:0] addr,
    input  logic [7:0]  data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [7:0]  read_data,
    output logic [7:0]  io_code,
    output logic [15:0] pc_out,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data
);

    smis_pkg::dp_cmd_t  dp_cmd;
    smis_pkg::dp_stat_t dp_stat;

    smis_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .stat(dp_stat), .cmd(dp_cmd)
    );

    smis_dp #(
        .DATA_STACK_DEPTH(DATA_STACK_DEPTH),
        .CALL_STACK_DEPTH(CALL_STACK_DEPTH),
        .ROM_TOP(ROM_TOP)
    ) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(dp_cmd), .stat(dp_stat),
        .in_cmd(cmd), .addr(addr), .data(data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .out_valid(out_valid), .out_ready(out_ready), .status(status),
        .read_data(read_data), .io_code(io_code), .pc_out(pc_out)
    );

    // The sequencer takes one item at a time.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("item accepted while busy");

    // A result is only loaded into a free output register.
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.out_load |-> (!out_valid || out_ready))
        else $error("result overwrote a pending result");

    // A new result always comes from a busy sequencer.
    a_rise_busy: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.out_load |-> !in_ready)
        else $error("result loaded while idle");

endmodule

// File: rtl/smis_ram.sv
// ----------------------------------------------------------------------------
// smis_ram: generic single-port-write RAM
// One write and one read port; read data is registered.
// ----------------------------------------------------------------------------
module smis_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_q [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_q[waddr] <= wdata;
        end
        rdata_reg <= mem_q[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/smis_ctrl.sv
// ----------------------------------------------------------------------------
// smis_ctrl: sequencer of the stack machine step block
// Walks host commands and instructions (fetch, operand reads, execute) to a result.
// ----------------------------------------------------------------------------
module smis_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  smis_pkg::dp_stat_t  stat,
    output smis_pkg::dp_cmd_t   cmd
);

    smis_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= smis_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        in_ready     = 1'b0;
        cmd.phase    = smis_pkg::PH_NONE;
        cmd.out_load = 1'b0;
        case (state_reg)
            smis_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.phase = smis_pkg::PH_ACCEPT;
                    case (stat.in_cmd)
                        smis_pkg::CMD_READ: state_next = smis_pkg::S_RD;
                        smis_pkg::CMD_EXEC: state_next = smis_pkg::S_FETCH;
                        default:            state_next = smis_pkg::S_DONE;
                    endcase
                end
            end
            smis_pkg::S_RD:
            begin
                cmd.phase  = smis_pkg::PH_HOSTRD;
                state_next = smis_pkg::S_DONE;
            end
            smis_pkg::S_FETCH:
            begin
                cmd.phase  = smis_pkg::PH_FETCH;
                state_next = smis_pkg::S_OP;
            end
            smis_pkg::S_OP:
            begin
                cmd.phase  = smis_pkg::PH_OP;
                state_next = smis_pkg::S_B;
            end
            smis_pkg::S_B:
            begin
                cmd.phase  = smis_pkg::PH_B;
                state_next = smis_pkg::S_C;
            end
            smis_pkg::S_C:
            begin
                cmd.phase  = smis_pkg::PH_C;
                state_next = smis_pkg::S_EXEC;
            end
            smis_pkg::S_EXEC:
            begin
                cmd.phase = smis_pkg::PH_EXEC;
                case (stat.nxt)
                    smis_pkg::NX_KEY: state_next = smis_pkg::S_KADDR;
                    smis_pkg::NX_DIV: state_next = smis_pkg::S_DIV;
                    smis_pkg::NX_CLR: state_next = smis_pkg::S_CLR;
                    default:          state_next = smis_pkg::S_DONE;
                endcase
            end
            smis_pkg::S_DIV:
            begin
                cmd.phase = smis_pkg::PH_DIV;
                if (stat.div_last)
                begin
                    state_next = smis_pkg::S_DIVWB;
                end
            end
            smis_pkg::S_DIVWB:
            begin
                cmd.phase  = smis_pkg::PH_DIVWB;
                state_next = smis_pkg::S_KADDR;
            end
            smis_pkg::S_CLR:
            begin
                cmd.phase = smis_pkg::PH_CLR;
                if (stat.clr_last)
                begin
                    state_next = smis_pkg::S_KADDR;
                end
            end
            smis_pkg::S_KADDR:
            begin
                cmd.phase  = smis_pkg::PH_KADDR;
                state_next = smis_pkg::S_KEY;
            end
            smis_pkg::S_KEY:
            begin
                cmd.phase  = smis_pkg::PH_KEY;
                state_next = smis_pkg::S_DONE;
            end
            smis_pkg::S_DONE:
            begin
                if (!stat.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = smis_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = smis_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/smis_dp.sv
// ----------------------------------------------------------------------------
// smis_dp: datapath of the stack machine step block
// Memory, both stacks, machine registers, divider, screen clear and output.
// ----------------------------------------------------------------------------
module smis_dp #(
    parameter int DATA_STACK_DEPTH = 256,
    parameter int CALL_STACK_DEPTH = 256,
    parameter int ROM_TOP          = 40960
) (
    input  logic               clk,
    input  logic               rst_n,
    input  smis_pkg::dp_cmd_t  cmd,
    output smis_pkg::dp_stat_t stat,
    input  logic [1:0]         in_cmd,
    input  logic [15:0]        addr,
    input  logic [7:0]         data,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [7:0]         cfg_data,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [2:0]         status,
    output logic [7:0]         read_data,
    output logic [7:0]         io_code,
    output logic [15:0]        pc_out
);

    localparam int DS_AW = $clog2(DATA_STACK_DEPTH);
    localparam int CS_AW = $clog2(CALL_STACK_DEPTH);
    localparam logic [DS_AW-1:0] DS_MAX = DS_AW'(DATA_STACK_DEPTH - 1);
    localparam logic [CS_AW-1:0] CS_MAX = CS_AW'(CALL_STACK_DEPTH - 1);
    localparam logic [15:0] ROM_LIMIT = 16'(ROM_TOP);

    logic [15:0]      pc_reg, ret_reg;
    logic [DS_AW-1:0] dd_reg;
    logic [CS_AW-1:0] cd_reg;
    logic [7:0]       io_reg, key_reg, op_reg, a_reg, b_reg, c_reg, imm_reg, rd_reg;
    logic             brk_reg;
    logic [2:0]       sts_reg, dcnt_reg;
    logic [7:0]       rem_reg, quo_reg;
    logic [11:0]      clr_reg;
    logic             out_valid_reg;
    logic [2:0]       out_sts_reg;
    logic [7:0]       out_rd_reg, out_io_reg;
    logic [15:0]      out_pc_reg;

    logic [15:0]      mem_raddr, mem_waddr;
    logic             mem_we;
    logic [7:0]       mem_wdata, mem_rdata;
    logic [DS_AW-1:0] ds_raddr, ds_waddr;
    logic             ds_we;
    logic [7:0]       ds_wdata, ds_rdata;
    logic             cs_we;
    logic [15:0]      cs_rdata;

    // Execute decode.
    logic [15:0]      tgt;
    logic [15:0]      prod;
    logic [7:0]       alu;
    logic [15:0]      ex_pc;
    logic [DS_AW-1:0] ex_dd;
    logic [CS_AW-1:0] ex_cd;
    logic [7:0]       ex_io;
    logic [2:0]       ex_sts;
    logic             ex_ds_we, ex_cs_we, ex_mem_we;
    logic [DS_AW-1:0] ex_ds_idx;
    logic [7:0]       ex_ds_val;
    smis_pkg::next_t  ex_nxt;
    logic             d_lt1, d_lt2, d_lt3;
    logic [8:0]       trial;

    smis_ram #(.WIDTH(8), .DEPTH(65536)) u_mem (
        .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
        .raddr(mem_raddr), .rdata(mem_rdata)
    );

    smis_ram #(.WIDTH(8), .DEPTH(DATA_STACK_DEPTH)) u_dstack (
        .clk(clk), .we(ds_we), .waddr(ds_waddr), .wdata(ds_wdata),
        .raddr(ds_raddr), .rdata(ds_rdata)
    );

    smis_ram #(.WIDTH(16), .DEPTH(CALL_STACK_DEPTH)) u_cstack (
        .clk(clk), .we(cs_we), .waddr(cd_reg), .wdata(pc_reg),
        .raddr(cd_reg - CS_AW'(1)), .rdata(cs_rdata)
    );

    assign tgt   = {b_reg, a_reg};
    assign prod  = a_reg * b_reg;
    assign d_lt1 = (dd_reg == '0);
    assign d_lt2 = (dd_reg < DS_AW'(2));
    assign d_lt3 = (dd_reg < DS_AW'(3));
    assign trial = {rem_reg, quo_reg[7]} - {1'b0, a_reg};

    always_comb
    begin
        case (op_reg)
            smis_pkg::OP_ADD:  alu = a_reg + b_reg;
            smis_pkg::OP_SUB:  alu = b_reg - a_reg;
            smis_pkg::OP_MUL:  alu = prod[7:0];
            smis_pkg::OP_NAND: alu = ~(a_reg & b_reg);
            smis_pkg::OP_EQ:   alu = {7'd0, a_reg == b_reg};
            default:           alu = {7'd0, a_reg < b_reg};
        endcase
    end

    always_comb
    begin
        ex_pc     = pc_reg + 16'd1;
        ex_dd     = dd_reg;
        ex_cd     = cd_reg;
        ex_io     = io_reg;
        ex_sts    = smis_pkg::ST_OK;
        ex_ds_we  = 1'b0;
        ex_cs_we  = 1'b0;
        ex_mem_we = 1'b0;
        ex_ds_idx = dd_reg - DS_AW'(2);
        ex_ds_val = alu;
        ex_nxt    = smis_pkg::NX_KEY;
        case (op_reg)
            smis_pkg::OP_PUSH, smis_pkg::OP_KEY:
            begin
                if (dd_reg == DS_MAX)
                begin
                    ex_sts = smis_pkg::ST_DOVER;
                end
                else
                begin
                    ex_ds_we  = 1'b1;
                    ex_ds_idx = dd_reg;
                    ex_dd     = dd_reg + DS_AW'(1);
                    if (op_reg == smis_pkg::OP_PUSH)
                    begin
                        ex_ds_val = imm_reg;
                        ex_pc     = pc_reg + 16'd2;
                    end
                    else
                    begin
                        ex_ds_val = key_reg;
                    end
                end
            end
            smis_pkg::OP_POP:
            begin
                if (d_lt1) ex_sts = smis_pkg::ST_DUNDER;
                else       ex_dd  = dd_reg - DS_AW'(1);
            end
            smis_pkg::OP_CLEAR:
            begin
                ex_dd = '0;
            end
            smis_pkg::OP_ADD, smis_pkg::OP_SUB, smis_pkg::OP_MUL, smis_pkg::OP_NAND,
            smis_pkg::OP_EQ, smis_pkg::OP_LESS, smis_pkg::OP_DIV, smis_pkg::OP_MOD:
            begin
                if (d_lt2)
                begin
                    ex_sts = smis_pkg::ST_DUNDER;
                end
                else if ((op_reg == smis_pkg::OP_DIV || op_reg == smis_pkg::OP_MOD)
                         && a_reg == 8'd0)
                begin
                    ex_sts = smis_pkg::ST_DIVZ;
                end
                else if (op_reg == smis_pkg::OP_DIV || op_reg == smis_pkg::OP_MOD)
                begin
                    // The divider writes back and moves pc when it finishes.
                    ex_pc  = pc_reg;
                    ex_nxt = smis_pkg::NX_DIV;
                end
                else
                begin
                    ex_ds_we = 1'b1;
                    ex_dd    = dd_reg - DS_AW'(1);
                end
            end
            smis_pkg::OP_JNZ:
            begin
                if (d_lt3)
                begin
                    ex_sts = smis_pkg::ST_DUNDER;
                end
                else
                begin
                    ex_dd = dd_reg - DS_AW'(3);
                    if (c_reg != 8'd0)
                    begin
                        ex_pc  = tgt;
                        ex_nxt = smis_pkg::NX_DONE;
                    end
                end
            end
            smis_pkg::OP_JMP:
            begin
                if (d_lt2)
                begin
                    ex_sts = smis_pkg::ST_DUNDER;
                end
                else
                begin
                    ex_dd  = dd_reg - DS_AW'(2);
                    ex_pc  = tgt;
                    ex_nxt = smis_pkg::NX_DONE;
                end
            end
            smis_pkg::OP_CALL:
            begin
                if (cd_reg == CS_MAX)
                begin
                    ex_sts = smis_pkg::ST_COVER;
                end
                else if (d_lt2)
                begin
                    ex_sts = smis_pkg::ST_DUNDER;
                end
                else
                begin
                    ex_cs_we = 1'b1;
                    ex_cd    = cd_reg + CS_AW'(1);
                    ex_dd    = dd_reg - DS_AW'(2);
                    ex_pc    = tgt;
                    ex_nxt   = smis_pkg::NX_DONE;
                end
            end
            smis_pkg::OP_RET:
            begin
                if (cd_reg == '0)
                begin
                    ex_sts = smis_pkg::ST_CUNDER;
                end
                else
                begin
                    ex_cd = cd_reg - CS_AW'(1);
                    ex_pc = ret_reg + 16'd1;
                end
            end
            smis_pkg::OP_LOAD:
            begin
                if (d_lt2)
                begin
                    ex_sts = smis_pkg::ST_DUNDER;
                end
                else
                begin
                    ex_ds_we  = 1'b1;
                    ex_ds_val = mem_rdata;
                    ex_dd     = dd_reg - DS_AW'(1);
                end
            end
            smis_pkg::OP_STORE:
            begin
                if (d_lt3)
                begin
                    ex_sts = smis_pkg::ST_DUNDER;
                end
                else
                begin
                    ex_mem_we = (tgt >= ROM_LIMIT);
                    ex_dd     = dd_reg - DS_AW'(3);
                end
            end
            smis_pkg::OP_IO:
            begin
                if (d_lt1)
                begin
                    ex_sts = smis_pkg::ST_DUNDER;
                end
                else
                begin
                    ex_dd = dd_reg - DS_AW'(1);
                    if (a_reg == smis_pkg::IO_CLR_A || a_reg == smis_pkg::IO_CLR_B)
                    begin
                        ex_nxt = smis_pkg::NX_CLR;
                    end
                    else
                    begin
                        ex_io  = a_reg;
                        ex_sts = smis_pkg::ST_IO;
                        ex_nxt = smis_pkg::NX_DONE;
                    end
                end
            end
            default:
            begin
            end
        endcase
        // A faulting instruction leaves all machine state alone.
        if (ex_sts != smis_pkg::ST_OK && ex_sts != smis_pkg::ST_IO)
        begin
            ex_pc     = pc_reg;
            ex_dd     = dd_reg;
            ex_cd     = cd_reg;
            ex_ds_we  = 1'b0;
            ex_cs_we  = 1'b0;
            ex_mem_we = 1'b0;
            ex_nxt    = smis_pkg::NX_DONE;
        end
    end

    // Memory and stack port selection.
    always_comb
    begin
        mem_raddr = pc_reg;
        mem_waddr = tgt;
        mem_wdata = c_reg;
        mem_we    = 1'b0;
        ds_raddr  = dd_reg - DS_AW'(1);
        ds_waddr  = ex_ds_idx;
        ds_wdata  = ex_ds_val;
        ds_we     = 1'b0;
        cs_we     = 1'b0;
        case (cmd.phase)
            smis_pkg::PH_ACCEPT:
            begin
                mem_raddr = addr;
                mem_waddr = addr;
                mem_wdata = data;
                mem_we    = (in_cmd == smis_pkg::CMD_WRITE);
            end
            smis_pkg::PH_OP:
            begin
                mem_raddr = pc_reg + 16'd1;
                ds_raddr  = dd_reg - DS_AW'(2);
            end
            smis_pkg::PH_B:
            begin
                ds_raddr = dd_reg - DS_AW'(3);
            end
            smis_pkg::PH_C:
            begin
                mem_raddr = tgt;
            end
            smis_pkg::PH_EXEC:
            begin
                mem_we = ex_mem_we;
                ds_we  = ex_ds_we;
                cs_we  = ex_cs_we;
            end
            smis_pkg::PH_DIVWB:
            begin
                ds_we    = 1'b1;
                ds_waddr = dd_reg - DS_AW'(2);
                ds_wdata = (op_reg == smis_pkg::OP_DIV) ? quo_reg : rem_reg;
            end
            smis_pkg::PH_CLR:
            begin
                mem_we    = 1'b1;
                mem_waddr = {smis_pkg::SCREEN_PAGE, clr_reg};
                mem_wdata = 8'd0;
            end
            default:
            begin
            end
        endcase
    end

    // Payload and scratch registers.
    always_ff @(posedge clk)
    begin
        case (cmd.phase)
            smis_pkg::PH_ACCEPT:
            begin
                sts_reg <= smis_pkg::ST_OK;
                rd_reg  <= 8'd0;
            end
            smis_pkg::PH_HOSTRD: rd_reg <= mem_rdata;
            smis_pkg::PH_OP:
            begin
                op_reg <= mem_rdata;
                a_reg  <= ds_rdata;
            end
            smis_pkg::PH_B:
            begin
                imm_reg <= mem_rdata;
                b_reg   <= ds_rdata;
                ret_reg <= cs_rdata;
            end
            smis_pkg::PH_C: c_reg <= ds_rdata;
            smis_pkg::PH_EXEC:
            begin
                sts_reg  <= ex_sts;
                rem_reg  <= 8'd0;
                quo_reg  <= b_reg;
                dcnt_reg <= 3'd0;
                clr_reg  <= 12'd0;
            end
            smis_pkg::PH_DIV:
            begin
                // Restoring division, one quotient bit per cycle.
                if (!trial[8])
                begin
                    rem_reg <= trial[7:0];
                    quo_reg <= {quo_reg[6:0], 1'b1};
                end
                else
                begin
                    rem_reg <= {rem_reg[6:0], quo_reg[7]};
                    quo_reg <= {quo_reg[6:0], 1'b0};
                end
                dcnt_reg <= dcnt_reg + 3'd1;
            end
            smis_pkg::PH_CLR: clr_reg <= clr_reg + 12'd1;
            smis_pkg::PH_KEY:
            begin
                if (brk_reg && mem_rdata == smis_pkg::OP_KEY)
                begin
                    sts_reg <= smis_pkg::ST_KEY;
                end
            end
            default:
            begin
            end
        endcase
        if (cmd.out_load)
        begin
            out_sts_reg <= sts_reg;
            out_rd_reg  <= rd_reg;
            out_io_reg  <= io_reg;
            out_pc_reg  <= pc_reg;
        end
    end

    // Machine state, configuration and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= 16'd0;
            dd_reg        <= '0;
            cd_reg        <= '0;
            io_reg        <= smis_pkg::IO_NONE;
            brk_reg       <= 1'b0;
            key_reg       <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            case (cmd.phase)
                smis_pkg::PH_FETCH: io_reg <= smis_pkg::IO_NONE;
                smis_pkg::PH_EXEC:
                begin
                    pc_reg <= ex_pc;
                    dd_reg <= ex_dd;
                    cd_reg <= ex_cd;
                    io_reg <= ex_io;
                end
                smis_pkg::PH_DIVWB:
                begin
                    pc_reg <= pc_reg + 16'd1;
                    dd_reg <= dd_reg - DS_AW'(1);
                end
                default:
                begin
                end
            endcase
            if (cfg_we)
            begin
                case (cfg_index)
                    smis_pkg::REG_BREAK: brk_reg <= cfg_data[0];
                    smis_pkg::REG_KEYS:  key_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.in_cmd   = in_cmd;
    assign stat.nxt      = ex_nxt;
    assign stat.div_last = (dcnt_reg == 3'd7);
    assign stat.clr_last = &clr_reg;
    assign stat.out_busy = out_valid_reg & ~out_ready;

    assign out_valid = out_valid_reg;
    assign status    = out_sts_reg;
    assign read_data = out_rd_reg;
    assign io_code   = out_io_reg;
    assign pc_out    = out_pc_reg;

endmodule
